@@ src/siacpu_pkg.sv @@
package siacpu_pkg;

   localparam int STORE_LINES_DEF = 32;
   localparam int WORD_W          = 32;
   localparam int LINE_W          = 5;

   // item operations
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_START = 2'd2,
      OP_STEP  = 2'd3
   } op_type;

   // instruction function codes, bits 15..13 of the instruction word
   typedef enum logic [2:0] {
      FN_JMP     = 3'd0,
      FN_JRP     = 3'd1,
      FN_LDN     = 3'd2,
      FN_STO     = 3'd3,
      FN_SUB     = 3'd4,
      FN_SUB_ALT = 3'd5,
      FN_CMP     = 3'd6,
      FN_STP     = 3'd7
   } fn_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_OPER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [LINE_W-1:0] line_address;
      logic [WORD_W-1:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic [WORD_W-1:0] accumulator_value;
      logic [WORD_W-1:0] control_instruction;
      logic [WORD_W-1:0] present_instruction;
      logic              halted;
      logic              step_ok;
   } rsp_payload_type;

endpackage

@@ src/siacpu_if.sv @@
interface siacpu_req_if
   import siacpu_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface siacpu_rsp_if
   import siacpu_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/seven_instruction_accumulator_cpu_unit.sv @@
// Stored-program accumulator machine with a STORE_LINES x 32 bit store.
// req_if carries one beat per item: write line, read line, start, or single
// step. rsp_if returns exactly one beat per item with the read word, the
// accumulator, CI, PI, the halted flag and step_ok.
// The store is a synchronous RAM with a registered read. A step increments CI
// and reads the fetch line, then reads the operand line (or writes it for a
// store instruction), so the store port sets the pace: a step passes FETCH
// and OPER (store, skip and halt go from FETCH to DONE), a read passes READ,
// and a write or start goes straight to DONE. Each item's result leaves
// through the result register.
// The next item is accepted in the cycle its predecessor moves into the
// result register; a stalled receiver holds the result register, and one
// further finished item waits in the sequencer until the register frees.
// Store accesses never overlap within an item window, so no forwarding.
// Reset clears the accumulator, CI and PI, stops the machine and empties the
// result register; store contents are undefined until written.
module seven_instruction_accumulator_cpu_unit
   import siacpu_pkg::*;
#(
   parameter int STORE_LINES = STORE_LINES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   siacpu_req_if.sink   req_if,
   siacpu_rsp_if.source rsp_if
);

   localparam int AW = (STORE_LINES > 1) ? $clog2(STORE_LINES) : 1;
   localparam logic [LINE_W:0] LINE_LIMIT = (LINE_W+1)'(STORE_LINES);

   // store
   logic [WORD_W-1:0] mem [STORE_LINES];
   logic [WORD_W-1:0] mem_q_ff;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;

   // machine and sequencer registers
   state_type         state_ff, state_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] ci_ff, ci_in;
   logic [WORD_W-1:0] pi_ff, pi_in;
   logic              stop_ff, stop_in;
   logic [WORD_W-1:0] res_read_ff, res_read_in;
   logic              res_ok_ff, res_ok_in;
   logic [LINE_W-1:0] line_ff, line_in;
   rsp_payload_type   out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              out_free;
   logic              accept;
   logic [WORD_W-1:0] ci_plus;
   logic [WORD_W-1:0] operand;
   fn_type            fetch_fn;
   fn_type            exec_fn;

   function automatic logic line_ok(input logic [LINE_W-1:0] line);
      return {1'b0, line} < LINE_LIMIT;
   endfunction

   assign out_free      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == ST_IDLE) || (state_ff == ST_DONE && out_free);
   assign accept        = req_if.valid && req_if.ready;
   assign ci_plus       = ci_ff + 1'b1;
   assign fetch_fn      = fn_type'(mem_q_ff[15:13]);
   assign exec_fn       = fn_type'(pi_ff[15:13]);
   assign operand       = line_ok(pi_ff[LINE_W-1:0]) ? mem_q_ff : '0;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.payload = out_ff;

   // store port, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      ci_in        = ci_ff;
      pi_in        = pi_ff;
      stop_in      = stop_ff;
      res_read_in  = res_read_ff;
      res_ok_in    = res_ok_ff;
      line_in      = line_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      wr_en        = 1'b0;
      wr_addr      = req_if.payload.line_address[AW-1:0];
      wr_data      = req_if.payload.write_data;
      rd_addr      = req_if.payload.line_address[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_READ: begin
            res_read_in = line_ok(line_ff) ? mem_q_ff : '0;
            state_in    = ST_DONE;
         end
         ST_FETCH: begin
            // instruction word arrives, start operand access
            pi_in   = mem_q_ff;
            rd_addr = mem_q_ff[AW-1:0];
            unique case (fetch_fn)
               FN_STO: begin
                  wr_en     = line_ok(mem_q_ff[LINE_W-1:0]);
                  wr_addr   = mem_q_ff[AW-1:0];
                  wr_data   = acc_ff;
                  res_ok_in = 1'b1;
                  state_in  = ST_DONE;
               end
               FN_CMP: begin
                  if (acc_ff[WORD_W-1]) begin
                     ci_in = ci_plus;
                  end
                  res_ok_in = 1'b1;
                  state_in  = ST_DONE;
               end
               FN_STP: begin
                  stop_in   = 1'b1;
                  res_ok_in = 1'b1;
                  state_in  = ST_DONE;
               end
               default: begin
                  state_in = ST_OPER;
               end
            endcase
         end
         ST_OPER: begin
            // operand word arrives
            unique case (exec_fn)
               FN_JMP:             ci_in  = operand;
               FN_JRP:             ci_in  = ci_ff + operand;
               FN_LDN:             acc_in = '0 - operand;
               FN_SUB, FN_SUB_ALT: acc_in = acc_ff - operand;
               default: begin
               end
            endcase
            res_ok_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               out_in.read_data           = res_read_ff;
               out_in.accumulator_value   = acc_ff;
               out_in.control_instruction = ci_ff;
               out_in.present_instruction = pi_ff;
               out_in.halted              = stop_ff;
               out_in.step_ok             = res_ok_ff;
               out_valid_in               = 1'b1;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // new item beat
      if (accept) begin
         res_read_in = '0;
         res_ok_in   = 1'b0;
         line_in     = req_if.payload.line_address;
         unique case (op_type'(req_if.payload.operation))
            OP_WRITE: begin
               wr_en    = line_ok(req_if.payload.line_address);
               state_in = ST_DONE;
            end
            OP_READ: begin
               state_in = ST_READ;
            end
            OP_START: begin
               acc_in   = '0;
               ci_in    = '0;
               pi_in    = '0;
               stop_in  = 1'b0;
               state_in = ST_DONE;
            end
            OP_STEP: begin
               if (stop_ff) begin
                  state_in = ST_DONE;
               end else begin
                  ci_in   = ci_plus;
                  rd_addr = ci_plus[AW-1:0];
                  if (line_ok(ci_plus[LINE_W-1:0])) begin
                     state_in = ST_FETCH;
                  end else begin
                     stop_in  = 1'b1;
                     state_in = ST_DONE;
                  end
               end
            end
            default: begin
               state_in = ST_DONE;
            end
         endcase
      end
   end

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         ci_ff        <= '0;
         pi_ff        <= '0;
         stop_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ci_ff        <= ci_in;
         pi_ff        <= pi_in;
         stop_ff      <= stop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_read_ff <= res_read_in;
      res_ok_ff   <= res_ok_in;
      line_ff     <= line_in;
      out_ff      <= out_in;
   end

endmodule
